FILE: hdl/quadratic_probe_hash_table_assert.svh
// Assertion helpers for the hash table block.
// Each macro expects clk_i and rst_ni in scope.
`ifndef QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication.
`define QPHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QPHT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/qpht_pkg.sv
`default_nettype none

package qpht_pkg;

  localparam int unsigned SLOTS_DEF   = 1024;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned STAT_W      = 3;
  localparam int unsigned SIDX_W      = 10;
  localparam int unsigned BIT_W       = $clog2(KEY_W);
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [SIDX_W-1:0] sidx_t;
  typedef logic [BIT_W-1:0]  bit_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_SEARCH = 2'd1;
  localparam mode_t MODE_CLEAR  = 2'd2;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_FULL      = 3'd1;
  localparam status_t ST_FOUND     = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_CLEARED   = 3'd4;

  // Register select: paddr bit 2 picks the word, table_size is word 0.
  localparam logic REG_TABLE_SIZE = 1'b0;

  localparam cnt_t TABLE_SIZE_RST = 11'd1024;

  // (a + b + cin) mod m, for a and b below m.
  function automatic cnt_t mod_add(input cnt_t a, input cnt_t b, input logic cin,
                                   input cnt_t m);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b} + {{CNT_W{1'b0}}, cin};
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
    return sum[CNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/qpht_ram.sv
`default_nettype none

module qpht_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = qpht_pkg::SLOTS_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/quadratic_probe_hash_table.sv
// Flow: insert and search first reduce the key mod size, one bit per cycle, then probe the
//   slot memory until the item settles; an insert that finds no free probed slot then scans
//   the slots from the first. A clear frees every slot.
// Items: one item at a time; each probe reads the slot memory through its registered read
//   port and uses the shared mod-add unit.
// Reset: a clearing pass frees every slot, s_axis_tready stays low meanwhile.
`default_nettype none

`include "quadratic_probe_hash_table_assert.svh"

module quadratic_probe_hash_table #(
  parameter int unsigned SLOTS = qpht_pkg::SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qpht_pkg::APB_AW-1:0]      paddr,
  input  logic [qpht_pkg::APB_DW-1:0]      pwdata,
  output logic [qpht_pkg::APB_DW-1:0]      prdata,
  output logic                             pready,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [qpht_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // key[30:0], zero pad
  input  logic [qpht_pkg::MODE_W-1:0]      s_axis_tuser,  // mode[1:0]
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [qpht_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // probe_count[10:0], slot_index[20:11], pad
  output logic [qpht_pkg::STAT_W-1:0]      m_axis_tuser   // status[2:0]
);

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned RamW = qpht_pkg::KEY_W + 1;

  typedef logic [IdxW-1:0] idx_t;

  localparam idx_t LastSlot = idx_t'(SLOTS - 1);

  typedef enum logic [8:0] {
    ST_INIT      = 9'b000000001,
    ST_IDLE      = 9'b000000010,
    ST_DIV       = 9'b000000100,
    ST_PROBE     = 9'b000001000,
    ST_CHECK     = 9'b000010000,
    ST_SCAN      = 9'b000100000,
    ST_SCAN_CHK  = 9'b001000000,
    ST_CLEAR     = 9'b010000000,
    ST_DONE      = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  qpht_pkg::cnt_t    cfg_q;
  qpht_pkg::cnt_t    eff_size;
  qpht_pkg::cnt_t    s_q, s_d;
  qpht_pkg::mode_t   mode_q, mode_d;
  qpht_pkg::key_t    key_q, key_d;
  qpht_pkg::bit_t    bit_q, bit_d;
  qpht_pkg::cnt_t    h_q, h_d;
  qpht_pkg::cnt_t    d_q, d_d;
  qpht_pkg::cnt_t    i_q, i_d;
  idx_t              clr_q, clr_d;
  qpht_pkg::status_t res_status_q, res_status_d;
  qpht_pkg::cnt_t    res_count_q, res_count_d;
  qpht_pkg::sidx_t   res_slot_q, res_slot_d;

  logic              m_valid_q;
  qpht_pkg::status_t m_status_q;
  qpht_pkg::cnt_t    m_count_q;
  qpht_pkg::sidx_t   m_slot_q;

  logic              cfg_we;
  logic              out_free;
  logic              out_load;
  logic              key_bit;
  qpht_pkg::cnt_t    unit_b;
  logic              unit_c;
  qpht_pkg::cnt_t    unit_y;
  qpht_pkg::cnt_t    d_next;
  logic [qpht_pkg::CNT_W:0] d_sum;
  qpht_pkg::cnt_t    i_inc;
  logic              clearing;
  logic              ram_we;
  logic              ram_re;
  idx_t              ram_waddr;
  logic [RamW-1:0]   ram_wdata;
  logic [RamW-1:0]   ram_rdata;
  logic              rd_used;
  qpht_pkg::key_t    rd_key;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == qpht_pkg::REG_TABLE_SIZE);
  assign prdata = (paddr[2] == qpht_pkg::REG_TABLE_SIZE) ? qpht_pkg::APB_DW'(cfg_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= qpht_pkg::TABLE_SIZE_RST;
    end else if (cfg_we) begin
      cfg_q <= pwdata[qpht_pkg::CNT_W-1:0];
    end
  end

  // saturate into 1..SLOTS
  always_comb begin
    if (cfg_q == '0) begin
      eff_size = qpht_pkg::cnt_t'(1);
    end else if (32'(cfg_q) > SLOTS) begin
      eff_size = qpht_pkg::cnt_t'(SLOTS);
    end else begin
      eff_size = cfg_q;
    end
  end

  // ---------------- shared mod-add unit ----------------
  assign key_bit = key_q[qpht_pkg::bit_t'(qpht_pkg::KEY_W - 1) - bit_q];

  always_comb begin
    unique case (state_q)
      ST_DIV: begin
        // remainder step: 2*rem + next key bit
        unit_b = h_q;
        unit_c = key_bit;
      end
      ST_SCAN_CHK: begin
        unit_b = '0;
        unit_c = 1'b1;
      end
      default: begin
        unit_b = d_q;
        unit_c = 1'b0;
      end
    endcase
  end

  assign unit_y = qpht_pkg::mod_add(h_q, unit_b, unit_c, s_q);

  // probe step grows by 2 each probe: advance it mod size
  assign d_sum = {1'b0, d_q} + (qpht_pkg::CNT_W + 1)'(2);
  always_comb begin
    if (s_q == qpht_pkg::cnt_t'(1)) begin
      d_next = '0;
    end else if (d_sum >= {1'b0, s_q}) begin
      d_next = qpht_pkg::cnt_t'(d_sum - {1'b0, s_q});
    end else begin
      d_next = d_sum[qpht_pkg::CNT_W-1:0];
    end
  end

  assign i_inc = i_q + qpht_pkg::cnt_t'(1);

  // ---------------- slot memory: {used, key} ----------------
  assign clearing  = (state_q == ST_INIT) || (state_q == ST_CLEAR);
  assign rd_used   = ram_rdata[qpht_pkg::KEY_W];
  assign rd_key    = ram_rdata[qpht_pkg::KEY_W-1:0];
  assign ram_re    = (state_q == ST_PROBE) || (state_q == ST_SCAN);
  assign ram_we    = clearing ||
                     ((state_q == ST_CHECK) && (mode_q == qpht_pkg::MODE_INSERT) && !rd_used);
  assign ram_waddr = clearing ? clr_q : idx_t'(h_q);
  assign ram_wdata = clearing ? '0 : {1'b1, key_q};

  qpht_ram #(
    .WIDTH (RamW),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_t'(h_q)),
    .rdata_o (ram_rdata)
  );

  // ---------------- sequencer ----------------
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (state_q == ST_DONE) && out_free;
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    s_d          = s_q;
    mode_d       = mode_q;
    key_d        = key_q;
    bit_d        = bit_q;
    h_d          = h_q;
    d_d          = d_q;
    i_d          = i_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    res_slot_d   = res_slot_q;

    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        clr_d = clr_q + idx_t'(1);
        if (clr_q == LastSlot) begin
          if (state_q == ST_INIT) begin
            state_d = ST_IDLE;
          end else begin
            res_status_d = qpht_pkg::ST_CLEARED;
            res_count_d  = '0;
            res_slot_d   = '0;
            state_d      = ST_DONE;
          end
        end
      end

      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d = s_axis_tuser;
          key_d  = s_axis_tdata[qpht_pkg::KEY_W-1:0];
          s_d    = eff_size;
          unique case (s_axis_tuser)
            qpht_pkg::MODE_INSERT, qpht_pkg::MODE_SEARCH: begin
              h_d     = '0;
              bit_d   = '0;
              state_d = ST_DIV;
            end
            qpht_pkg::MODE_CLEAR: begin
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            default: begin
              res_status_d = qpht_pkg::ST_NOT_FOUND;
              res_count_d  = '0;
              res_slot_d   = '0;
              state_d      = ST_DONE;
            end
          endcase
        end
      end

      ST_DIV: begin
        h_d   = unit_y;
        bit_d = bit_q + qpht_pkg::bit_t'(1);
        if (bit_q == qpht_pkg::bit_t'(qpht_pkg::KEY_W - 1)) begin
          i_d     = '0;
          d_d     = (s_q <= qpht_pkg::cnt_t'(2)) ? '0 : qpht_pkg::cnt_t'(2);
          state_d = ST_PROBE;
        end
      end

      ST_PROBE: begin
        state_d = ST_CHECK;
      end

      ST_CHECK: begin
        // advance to the next probe unless this one settles the item or, for an insert, starts the scan
        h_d     = unit_y;
        d_d     = d_next;
        i_d     = i_inc;
        state_d = ST_PROBE;
        if (mode_q == qpht_pkg::MODE_INSERT) begin
          if (!rd_used) begin
            res_status_d = qpht_pkg::ST_INSERTED;
            res_count_d  = i_inc;
            res_slot_d   = qpht_pkg::sidx_t'(h_q);
            state_d      = ST_DONE;
          end else if (i_inc == s_q) begin
            // no free probed slot: look for any free slot to pick the reported count (status is full either way)
            h_d     = '0;
            state_d = ST_SCAN;
          end
        end else begin
          if (rd_used && (rd_key == key_q)) begin
            res_status_d = qpht_pkg::ST_FOUND;
            res_count_d  = i_inc;
            res_slot_d   = qpht_pkg::sidx_t'(h_q);
            state_d      = ST_DONE;
          end else if (!rd_used || (i_inc == s_q)) begin
            res_status_d = qpht_pkg::ST_NOT_FOUND;
            res_count_d  = i_inc;
            res_slot_d   = '0;
            state_d      = ST_DONE;
          end
        end
      end

      ST_SCAN: begin
        state_d = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (!rd_used) begin
          res_status_d = qpht_pkg::ST_FULL;
          res_count_d  = s_q;
          res_slot_d   = '0;
          state_d      = ST_DONE;
        end else if (unit_y == '0) begin
          // wrapped: every slot in use
          res_status_d = qpht_pkg::ST_FULL;
          res_count_d  = '0;
          res_slot_d   = '0;
          state_d      = ST_DONE;
        end else begin
          h_d     = unit_y;
          state_d = ST_SCAN;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q          <= s_d;
    mode_q       <= mode_d;
    key_q        <= key_d;
    bit_q        <= bit_d;
    h_q          <= h_d;
    d_q          <= d_d;
    i_q          <= i_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    res_slot_q   <= res_slot_d;
    if (out_load) begin
      m_status_q <= res_status_q;
      m_count_q  <= res_count_q;
      m_slot_q   <= res_slot_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{(qpht_pkg::OUT_TDATA_W - qpht_pkg::SIDX_W - qpht_pkg::CNT_W){1'b0}},
                          m_slot_q, m_count_q};

  // ---------------- assertions ----------------
  `QPHT_ASSERT_IMP(a_rem_below_size, state_q == ST_DIV, h_q < s_q,
                   "remainder reached table size")
  `QPHT_ASSERT_IMP(a_probe_in_table, state_q == ST_CHECK, (i_q < s_q) && (h_q < s_q),
                   "probe outside table")
  `QPHT_ASSERT_NXT(a_result_loaded, (state_q == ST_DONE) && (!m_valid_q || m_axis_tready),
                   m_valid_q && (state_q == ST_IDLE), "result not presented")

endmodule

`default_nettype wire
